// ===== src/tsp_pkg.sv =====
// Package of shared types, character constants and field range limits for the timestamp parser.
`default_nettype none

package tsp_pkg;

   typedef logic [7:0]         char_type;
   typedef logic [13:0]        year_type;
   typedef logic [3:0]         month_type;
   typedef logic [4:0]         day_type;
   typedef logic [4:0]         hour_type;
   typedef logic [5:0]         minute_type;
   typedef logic [5:0]         second_type;
   typedef logic signed [5:0]  zone_hour_type;
   typedef logic signed [6:0]  zone_minute_type;

   localparam char_type CHAR_0     = 8'h30;
   localparam char_type CHAR_9     = 8'h39;
   localparam char_type CHAR_DASH  = 8'h2D;
   localparam char_type CHAR_PLUS  = 8'h2B;
   localparam char_type CHAR_COLON = 8'h3A;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_T     = 8'h54;
   localparam char_type CHAR_Z     = 8'h5A;

   localparam logic [13:0] MONTH_MAX = 14'd12;
   localparam logic [13:0] DAY_MAX   = 14'd31;
   localparam logic [13:0] HOUR_LIM  = 14'd24;
   localparam logic [13:0] MIN_LIM   = 14'd60;

endpackage

`default_nettype wire

// ===== src/tsp_req_if.sv =====
// Character channel interface: one character and its end-of-string flag.
`default_nettype none

interface tsp_req_if;
   logic               valid;
   logic               ready;
   tsp_pkg::char_type  char_byte;
   logic               last_of_string;

   modport source (output valid, output char_byte, output last_of_string, input ready);
   modport sink   (input valid, input char_byte, input last_of_string, output ready);
endinterface

`default_nettype wire

// ===== src/tsp_rsp_if.sv =====
// Result channel interface: the parsed date, time and zone offset of one string.
`default_nettype none

interface tsp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      valid_res;
   tsp_pkg::year_type         year;
   tsp_pkg::month_type        month;
   tsp_pkg::day_type          day;
   tsp_pkg::hour_type         hour;
   tsp_pkg::minute_type       minute;
   tsp_pkg::second_type       second;
   tsp_pkg::zone_hour_type    offset_hours;
   tsp_pkg::zone_minute_type  offset_minutes;

   modport source (output valid, output valid_res, output year, output month, output day,
                   output hour, output minute, output second, output offset_hours,
                   output offset_minutes, input ready);
   modport sink   (input valid, input valid_res, input year, input month, input day,
                   input hour, input minute, input second, input offset_hours,
                   input offset_minutes, output ready);
endinterface

`default_nettype wire

// ===== src/iso8601_timestamp_parser_core.sv =====
// Streaming ISO 8601 date-time parser: one character per transaction, one result per string.
//
// The req_chan channel carries one ASCII character per transaction, with last_of_string
// set on the final character of a string. The rsp_chan channel carries exactly one
// transaction per string: valid_res, the date and time fields and the signed zone offset,
// all fields zero when the string did not match the grammar or a range check.
// A character is taken in every cycle in which req_chan.ready is high, by the single pass
// through the grammar position decode and the multiply-by-ten accumulate.
// The result of a string is presented in the cycle after its last character is accepted,
// from an output register that holds it until the receiver takes it.
// While that register is full and rsp_chan.ready is low, req_chan.ready is low, so the
// parser stalls without losing or repeating anything; when the receiver takes the result
// in the same cycle, a new character is still accepted.
// A synchronous, active-high reset returns the parser to the first year digit with the
// error flag and all fields cleared, and empties the output register.
// After the last character of every string the parser state returns to the same reset
// values, so strings follow one another with no gap.
`default_nettype none

module iso8601_timestamp_parser_core (
   input  wire        clock,
   input  wire        reset,
   tsp_req_if.sink    req_chan,
   tsp_rsp_if.source  rsp_chan
);

   // Grammar positions: each names the character expected next.
   localparam logic [4:0] POS_YEAR0    = 5'd0;
   localparam logic [4:0] POS_YEAR1    = 5'd1;
   localparam logic [4:0] POS_YEAR2    = 5'd2;
   localparam logic [4:0] POS_YEAR3    = 5'd3;
   localparam logic [4:0] POS_DASH1    = 5'd4;
   localparam logic [4:0] POS_MONTH0   = 5'd5;
   localparam logic [4:0] POS_MONTH1   = 5'd6;
   localparam logic [4:0] POS_DASH2    = 5'd7;
   localparam logic [4:0] POS_DAY0     = 5'd8;
   localparam logic [4:0] POS_DAY1     = 5'd9;
   localparam logic [4:0] POS_SEP      = 5'd10;
   localparam logic [4:0] POS_HOUR0    = 5'd11;
   localparam logic [4:0] POS_HOUR1    = 5'd12;
   localparam logic [4:0] POS_COLON1   = 5'd13;
   localparam logic [4:0] POS_MIN0     = 5'd14;
   localparam logic [4:0] POS_MIN1     = 5'd15;
   localparam logic [4:0] POS_AFT_MIN  = 5'd16;
   localparam logic [4:0] POS_SEC0     = 5'd17;
   localparam logic [4:0] POS_SEC1     = 5'd18;
   localparam logic [4:0] POS_AFT_SEC  = 5'd19;
   localparam logic [4:0] POS_AFT_Z    = 5'd20;
   localparam logic [4:0] POS_ZH0      = 5'd21;
   localparam logic [4:0] POS_ZH1      = 5'd22;
   localparam logic [4:0] POS_AFT_ZH   = 5'd23;
   localparam logic [4:0] POS_AFT_ZCOL = 5'd24;
   localparam logic [4:0] POS_ZM1      = 5'd25;
   localparam logic [4:0] POS_DONE     = 5'd26;

   // Parser state.
   logic [4:0]              pos_ff, pos_in;
   logic [13:0]             acc_ff, acc_in;
   logic                    err_ff, err_in;
   logic                    neg_ff, neg_in;
   tsp_pkg::year_type       year_ff, year_in;
   tsp_pkg::month_type      month_ff, month_in;
   tsp_pkg::day_type        day_ff, day_in;
   tsp_pkg::hour_type       hour_ff, hour_in;
   tsp_pkg::minute_type     minute_ff, minute_in;
   tsp_pkg::second_type     second_ff, second_in;
   logic [4:0]              zhour_ff, zhour_in;
   logic [5:0]              zmin_ff, zmin_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      res_ok_ff, res_ok_in;
   tsp_pkg::year_type         res_year_ff, res_year_in;
   tsp_pkg::month_type        res_month_ff, res_month_in;
   tsp_pkg::day_type          res_day_ff, res_day_in;
   tsp_pkg::hour_type         res_hour_ff, res_hour_in;
   tsp_pkg::minute_type       res_minute_ff, res_minute_in;
   tsp_pkg::second_type       res_second_ff, res_second_in;
   tsp_pkg::zone_hour_type    res_zhour_ff, res_zhour_in;
   tsp_pkg::zone_minute_type  res_zmin_ff, res_zmin_in;

   logic                accept;
   logic                last;
   tsp_pkg::char_type   ch;
   logic                dig;
   logic [3:0]          digit;
   logic [13:0]         acc_mac;
   logic                ok;

   assign ch     = req_chan.char_byte;
   assign last   = req_chan.last_of_string;
   assign accept = req_chan.valid && req_chan.ready;

   // The parser can take a character whenever the output register is empty or being emptied.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign dig     = (ch >= tsp_pkg::CHAR_0) && (ch <= tsp_pkg::CHAR_9);
   assign digit   = dig ? 4'(ch - tsp_pkg::CHAR_0) : 4'd0;
   // acc * 10 + digit, kept to the accumulator width.
   assign acc_mac = {acc_ff[10:0], 3'b000} + {acc_ff[12:0], 1'b0} + {10'd0, digit};

   // Next parser state after one character.
   always_comb begin
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      err_in    = err_ff;
      neg_in    = neg_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      zhour_in  = zhour_ff;
      zmin_in   = zmin_ff;

      if (!err_ff) begin
         unique case (pos_ff)
            POS_YEAR0, POS_MONTH0, POS_DAY0, POS_HOUR0, POS_MIN0, POS_SEC0, POS_ZH0: begin
               if (dig) begin
                  acc_in = {10'd0, digit};
                  pos_in = pos_ff + 5'd1;
               end else begin
                  err_in = 1'b1;
               end
            end
            POS_YEAR1, POS_YEAR2: begin
               if (dig) begin
                  acc_in = acc_mac;
                  pos_in = pos_ff + 5'd1;
               end else begin
                  err_in = 1'b1;
               end
            end
            POS_DASH1, POS_DASH2: begin
               if (ch == tsp_pkg::CHAR_DASH) pos_in = pos_ff + 5'd1;
               else err_in = 1'b1;
            end
            POS_COLON1: begin
               if (ch == tsp_pkg::CHAR_COLON) pos_in = POS_MIN0;
               else err_in = 1'b1;
            end
            POS_SEP: begin
               if (ch == tsp_pkg::CHAR_T || ch == tsp_pkg::CHAR_SPACE) pos_in = POS_HOUR0;
               else err_in = 1'b1;
            end
            POS_AFT_MIN, POS_AFT_SEC: begin
               // After minutes a colon opens the seconds; otherwise a zone or nothing.
               if (pos_ff == POS_AFT_MIN && ch == tsp_pkg::CHAR_COLON) begin
                  pos_in = POS_SEC0;
               end else if (ch == tsp_pkg::CHAR_Z) begin
                  pos_in = POS_AFT_Z;
               end else if (ch == tsp_pkg::CHAR_PLUS || ch == tsp_pkg::CHAR_DASH) begin
                  neg_in = (ch == tsp_pkg::CHAR_DASH);
                  pos_in = POS_ZH0;
               end else begin
                  err_in = 1'b1;
               end
            end
            POS_AFT_ZH: begin
               if (ch == tsp_pkg::CHAR_COLON) begin
                  pos_in = POS_AFT_ZCOL;
               end else if (dig) begin
                  acc_in = {10'd0, digit};
                  pos_in = POS_ZM1;
               end else begin
                  err_in = 1'b1;
               end
            end
            POS_AFT_ZCOL: begin
               if (dig) begin
                  acc_in = {10'd0, digit};
                  pos_in = POS_ZM1;
               end else begin
                  err_in = 1'b1;
               end
            end
            POS_YEAR3, POS_MONTH1, POS_DAY1, POS_HOUR1, POS_MIN1, POS_SEC1, POS_ZH1,
            POS_ZM1: begin
               // Last digit of a field: complete it, check its range and store it.
               if (!dig) begin
                  err_in = 1'b1;
               end else begin
                  acc_in = acc_mac;
                  unique case (pos_ff)
                     POS_YEAR3: begin
                        year_in = acc_mac;
                        pos_in  = POS_DASH1;
                     end
                     POS_MONTH1: begin
                        if (acc_mac == 14'd0 || acc_mac > tsp_pkg::MONTH_MAX) begin
                           err_in = 1'b1;
                        end else begin
                           month_in = acc_mac[3:0];
                           pos_in   = POS_DASH2;
                        end
                     end
                     POS_DAY1: begin
                        if (acc_mac == 14'd0 || acc_mac > tsp_pkg::DAY_MAX) begin
                           err_in = 1'b1;
                        end else begin
                           day_in = acc_mac[4:0];
                           pos_in = POS_SEP;
                        end
                     end
                     POS_HOUR1: begin
                        if (acc_mac >= tsp_pkg::HOUR_LIM) begin
                           err_in = 1'b1;
                        end else begin
                           hour_in = acc_mac[4:0];
                           pos_in  = POS_COLON1;
                        end
                     end
                     POS_MIN1: begin
                        if (acc_mac >= tsp_pkg::MIN_LIM) begin
                           err_in = 1'b1;
                        end else begin
                           minute_in = acc_mac[5:0];
                           pos_in    = POS_AFT_MIN;
                        end
                     end
                     POS_SEC1: begin
                        if (acc_mac >= tsp_pkg::MIN_LIM) begin
                           err_in = 1'b1;
                        end else begin
                           second_in = acc_mac[5:0];
                           pos_in    = POS_AFT_SEC;
                        end
                     end
                     POS_ZH1: begin
                        if (acc_mac >= tsp_pkg::HOUR_LIM) begin
                           err_in = 1'b1;
                        end else begin
                           zhour_in = acc_mac[4:0];
                           pos_in   = POS_AFT_ZH;
                        end
                     end
                     default: begin
                        if (acc_mac >= tsp_pkg::MIN_LIM) begin
                           err_in = 1'b1;
                        end else begin
                           zmin_in = acc_mac[5:0];
                           pos_in  = POS_DONE;
                        end
                     end
                  endcase
               end
            end
            default: begin
               // Anything after a complete string, or an unused position, is an error.
               err_in = 1'b1;
            end
         endcase
      end
   end

   // Result of a string, formed from the state after its last character.
   always_comb begin
      ok = !err_in && (pos_in == POS_AFT_MIN || pos_in == POS_AFT_SEC ||
                       pos_in == POS_AFT_Z || pos_in == POS_AFT_ZH ||
                       pos_in == POS_AFT_ZCOL || pos_in == POS_DONE);
      res_ok_in     = ok;
      res_year_in   = ok ? year_in   : '0;
      res_month_in  = ok ? month_in  : '0;
      res_day_in    = ok ? day_in    : '0;
      res_hour_in   = ok ? hour_in   : '0;
      res_minute_in = ok ? minute_in : '0;
      res_second_in = ok ? second_in : '0;
      res_zhour_in  = '0;
      res_zmin_in   = '0;
      if (ok) begin
         res_zhour_in = neg_in ? -$signed({1'b0, zhour_in}) : $signed({1'b0, zhour_in});
         res_zmin_in  = neg_in ? -$signed({1'b0, zmin_in})  : $signed({1'b0, zmin_in});
      end
   end

   // The output register fills on the last character and empties when the receiver takes it.
   always_comb begin
      if (accept && last) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         // Reset and the end of every string leave the parser in the same start state.
         pos_ff    <= POS_YEAR0;
         acc_ff    <= '0;
         err_ff    <= 1'b0;
         neg_ff    <= 1'b0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         zhour_ff  <= '0;
         zmin_ff   <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         err_ff    <= err_in;
         neg_ff    <= neg_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         zhour_ff  <= zhour_in;
         zmin_ff   <= zmin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last) begin
         res_ok_ff     <= res_ok_in;
         res_year_ff   <= res_year_in;
         res_month_ff  <= res_month_in;
         res_day_ff    <= res_day_in;
         res_hour_ff   <= res_hour_in;
         res_minute_ff <= res_minute_in;
         res_second_ff <= res_second_in;
         res_zhour_ff  <= res_zhour_in;
         res_zmin_ff   <= res_zmin_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.valid_res      = res_ok_ff;
   assign rsp_chan.year           = res_year_ff;
   assign rsp_chan.month          = res_month_ff;
   assign rsp_chan.day            = res_day_ff;
   assign rsp_chan.hour           = res_hour_ff;
   assign rsp_chan.minute         = res_minute_ff;
   assign rsp_chan.second         = res_second_ff;
   assign rsp_chan.offset_hours   = res_zhour_ff;
   assign rsp_chan.offset_minutes = res_zmin_ff;

endmodule

`default_nettype wire
